/* rtl/kce_pkg.sv */
// Keyframe curve evaluator package: key entry layout, codes, datapath ops,
// controller states and the status group between controller and datapath.
// No dependencies.
package kce_pkg;

  localparam int unsigned DIV_STEPS = 16;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic [1:0] MODE_CONST  = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_BEZIER = 2'd2;
  localparam logic [1:0] MODE_HOLD   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Q2.14 one, Q0.16 one
  localparam logic signed [17:0] EASE_ONE = 18'sd16384;
  localparam logic [16:0]        FRAC_ONE = 17'h10000;

  typedef struct packed {
    logic signed [31:0] kt;
    logic signed [31:0] kv;
    logic [1:0]         mode;
    logic signed [15:0] oh;
    logic signed [15:0] ih;
  } key_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_WRITE_NEW,
    OP_SHIFT,
    OP_SAVE,
    OP_CLAMP,
    OP_SEG,
    OP_DIV_STEP,
    OP_HOLD,
    OP_MUL_MT2,
    OP_MUL_TT2,
    OP_MUL_TT3,
    OP_MUL_P1A,
    OP_MUL_P1B,
    OP_MUL_P2A,
    OP_MUL_P2B,
    OP_ACC,
    OP_MUL_LIN,
    OP_MUL_EASE,
    OP_FINAL,
    OP_EMIT
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INS_CHK,
    S_INS_CMP,
    S_Q_RD,
    S_Q_CMP,
    S_DIV,
    S_MODE,
    S_MT2,
    S_TT2,
    S_TT3,
    S_P1A,
    S_P1B,
    S_P2A,
    S_P2B,
    S_ACC,
    S_MUL_EASE,
    S_MUL_LIN,
    S_FIN,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic       cmp_le;    // item time <= stored time
    logic       cmp_lt;    // item time <  stored time
    logic [1:0] left_mode;
  } dp_stat_t;

endpackage

/* rtl/kce_ram.sv */
// Generic single write, single read RAM with registered read data.
// No dependencies.
module kce_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/kce_datapath.sv */
// Datapath: key RAM, item capture, segment divider, shared multiplier and
// easing/saturation arithmetic. Depends on kce_pkg and kce_ram.
module kce_datapath #(
  parameter int unsigned MAX_KEYS = 64,
  localparam int unsigned AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1
) (
  input  logic               clk_i,
  input  logic signed [31:0] time_point_i,
  input  logic signed [31:0] key_value_i,
  input  logic [1:0]         interp_mode_i,
  input  logic signed [15:0] out_handle_i,
  input  logic signed [15:0] in_handle_i,
  input  kce_pkg::dp_op_e    op_i,
  input  logic [AW-1:0]      rd_addr_i,
  input  logic [AW-1:0]      wr_addr_i,
  output kce_pkg::dp_stat_t  stat_o,
  output logic signed [31:0] result_value_o
);
  import kce_pkg::*;

  key_t               new_q;
  key_t               left_q;
  key_t               rd_w;
  key_t               wdata_w;
  logic               we_w;
  logic signed [15:0] rih_q;
  logic [33:0]        rem_q;
  logic [32:0]        den_q;
  logic [15:0]        t_q;
  logic signed [32:0] dv_q;
  logic [16:0]        mt2_q;
  logic [15:0]        tt2_q;
  logic [15:0]        tt3_q;
  logic signed [49:0] p1_q;
  logic signed [50:0] p2_q;
  logic signed [25:0] ease_q;
  logic signed [59:0] prod_q;
  logic signed [31:0] res_q;
  logic signed [31:0] out_q;

  logic [16:0]        mt_w;
  logic signed [17:0] ih_term_w;
  logic signed [33:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [59:0] mul_p;
  logic [33:0]        r2_w;
  logic               ge_w;
  logic signed [55:0] sum_w;
  logic signed [55:0] acc_w;
  logic signed [45:0] fin_w;
  logic signed [31:0] sat_w;

  kce_ram #(
    .WIDTH ($bits(key_t)),
    .DEPTH (MAX_KEYS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we_w),
    .waddr_i (wr_addr_i),
    .wdata_i (wdata_w),
    .raddr_i (rd_addr_i),
    .rdata_o (rd_w)
  );

  assign we_w    = (op_i == OP_WRITE_NEW) || (op_i == OP_SHIFT);
  assign wdata_w = (op_i == OP_SHIFT) ? rd_w : new_q;

  assign stat_o.cmp_le    = $signed(new_q.kt) <= $signed(rd_w.kt);
  assign stat_o.cmp_lt    = $signed(new_q.kt) <  $signed(rd_w.kt);
  assign stat_o.left_mode = left_q.mode;

  assign mt_w      = FRAC_ONE - {1'b0, t_q};
  assign ih_term_w = EASE_ONE - 18'(rih_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_i)
      OP_MUL_MT2:  begin mul_a = 34'(mt_w);      mul_b = 26'(mt_w);   end
      OP_MUL_TT2:  begin mul_a = 34'(t_q);       mul_b = 26'(t_q);    end
      OP_MUL_TT3:  begin mul_a = 34'(tt2_q);     mul_b = 26'(t_q);    end
      OP_MUL_P1A:  begin mul_a = 34'(left_q.oh); mul_b = 26'(mt2_q);  end
      OP_MUL_P1B:  begin mul_a = p1_q[33:0];     mul_b = 26'(t_q);    end
      OP_MUL_P2A:  begin mul_a = 34'(ih_term_w); mul_b = 26'(mt_w);   end
      OP_MUL_P2B:  begin mul_a = p2_q[33:0];     mul_b = 26'(tt2_q);  end
      OP_MUL_LIN:  begin mul_a = 34'(dv_q);      mul_b = 26'(t_q);    end
      OP_MUL_EASE: begin mul_a = 34'(dv_q);      mul_b = ease_q;      end
      default:     begin mul_a = '0;             mul_b = '0;          end
    endcase
  end

  assign mul_p = 60'(mul_a) * 60'(mul_b);

  // restoring divide, one quotient bit a cycle
  assign r2_w = {rem_q[32:0], 1'b0};
  assign ge_w = r2_w >= {1'b0, den_q};

  assign sum_w = 56'(p1_q) + 56'(p2_q);
  assign acc_w = sum_w + (sum_w <<< 1) + $signed({10'b0, tt3_q, 30'b0});

  assign fin_w = 46'(left_q.kv) + 46'(prod_q >>> 16);

  always_comb begin
    if (fin_w > 46'sd2147483647) begin
      sat_w = 32'sh7fffffff;
    end else if (fin_w < -46'sd2147483648) begin
      sat_w = 32'sh80000000;
    end else begin
      sat_w = fin_w[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        new_q.kt   <= time_point_i;
        new_q.kv   <= key_value_i;
        new_q.mode <= interp_mode_i;
        new_q.oh   <= out_handle_i;
        new_q.ih   <= in_handle_i;
        res_q      <= '0;
      end
      OP_SAVE:  left_q <= rd_w;
      OP_CLAMP: res_q  <= rd_w.kv;
      OP_SEG: begin
        rem_q <= {1'b0, 33'(new_q.kt) - 33'(left_q.kt)};
        den_q <= 33'(rd_w.kt) - 33'(left_q.kt);
        dv_q  <= 33'(rd_w.kv) - 33'(left_q.kv);
        rih_q <= rd_w.ih;
        t_q   <= '0;
      end
      OP_DIV_STEP: begin
        rem_q <= ge_w ? (r2_w - {1'b0, den_q}) : r2_w;
        t_q   <= {t_q[14:0], ge_w};
      end
      OP_HOLD:     res_q  <= left_q.kv;
      OP_MUL_MT2:  mt2_q  <= mul_p[32:16];
      OP_MUL_TT2:  tt2_q  <= mul_p[31:16];
      OP_MUL_TT3:  tt3_q  <= mul_p[31:16];
      OP_MUL_P1A:  p1_q   <= mul_p[49:0];
      OP_MUL_P1B:  p1_q   <= mul_p[49:0];
      OP_MUL_P2A:  p2_q   <= mul_p[50:0];
      OP_MUL_P2B:  p2_q   <= mul_p[50:0];
      OP_ACC:      ease_q <= acc_w[55:30];
      OP_MUL_LIN:  prod_q <= mul_p;
      OP_MUL_EASE: prod_q <= mul_p;
      OP_FINAL:    res_q  <= sat_w;
      OP_EMIT:     out_q  <= res_q;
      default: ;
    endcase
  end

  assign result_value_o = out_q;

endmodule

/* rtl/kce_ctrl.sv */
// Controller: item handshake, key count, table walk sequencing, output
// valid/status. Drives the datapath through op and addresses. Needs kce_pkg.
module kce_ctrl #(
  parameter int unsigned MAX_KEYS = 64,
  localparam int unsigned AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1,
  localparam int unsigned CW = $clog2(MAX_KEYS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              command_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [6:0]        keys_held_o,
  output kce_pkg::dp_op_e   op_o,
  output logic [AW-1:0]     rd_addr_o,
  output logic [AW-1:0]     wr_addr_o,
  input  kce_pkg::dp_stat_t stat_i
);
  import kce_pkg::*;

  localparam int unsigned NW = $clog2(DIV_STEPS);

  ctrl_state_e   state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] count_q, count_d;
  logic [1:0]    st_q, st_d;
  logic          out_valid_q, out_valid_d;
  logic          accept_w;
  logic          hit_w;
  logic          last_w;
  logic          out_free_w;

  assign accept_w   = in_valid_i && (state_q == S_IDLE);
  assign hit_w      = (idx_q == '0) ? stat_i.cmp_le : stat_i.cmp_lt;
  assign last_w     = (CW'(idx_q) + CW'(1)) == count_q;
  assign out_free_w = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept_w) begin
          if (command_i == CMD_INSERT) begin
            state_d = (count_q == CW'(MAX_KEYS)) ? S_DONE : S_INS_CHK;
          end else begin
            state_d = (count_q == '0) ? S_DONE : S_Q_RD;
          end
        end
      end
      S_INS_CHK: state_d = (idx_q == '0) ? S_DONE : S_INS_CMP;
      S_INS_CMP: state_d = stat_i.cmp_le ? S_INS_CHK : S_DONE;
      S_Q_RD:    state_d = S_Q_CMP;
      S_Q_CMP: begin
        if (hit_w) begin
          state_d = (idx_q == '0) ? S_DONE : S_DIV;
        end else begin
          state_d = last_w ? S_DONE : S_Q_RD;
        end
      end
      S_DIV:     state_d = (cnt_q == NW'(DIV_STEPS - 1)) ? S_MODE : S_DIV;
      S_MODE: begin
        case (stat_i.left_mode)
          MODE_LINEAR: state_d = S_MUL_LIN;
          MODE_BEZIER: state_d = S_MT2;
          default:     state_d = S_DONE;
        endcase
      end
      S_MT2:      state_d = S_TT2;
      S_TT2:      state_d = S_TT3;
      S_TT3:      state_d = S_P1A;
      S_P1A:      state_d = S_P1B;
      S_P1B:      state_d = S_P2A;
      S_P2A:      state_d = S_P2B;
      S_P2B:      state_d = S_ACC;
      S_ACC:      state_d = S_MUL_EASE;
      S_MUL_EASE: state_d = S_FIN;
      S_MUL_LIN:  state_d = S_FIN;
      S_FIN:      state_d = S_DONE;
      S_DONE:     state_d = out_free_w ? S_IDLE : S_DONE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    op_o        = OP_NONE;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    count_d     = count_q;
    st_d        = st_q;
    out_valid_d = out_valid_q && out_stall_i;
    rd_addr_o   = idx_q;
    wr_addr_o   = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept_w) begin
          op_o = OP_LOAD;
          st_d = ST_OK;
          idx_d = '0;
          if (command_i == CMD_INSERT) begin
            if (count_q == CW'(MAX_KEYS)) begin
              st_d = ST_FULL;
            end else begin
              idx_d = AW'(count_q);
            end
          end else if (count_q == '0) begin
            st_d = ST_EMPTY;
          end
        end
      end
      S_INS_CHK: begin
        rd_addr_o = idx_q - AW'(1);
        if (idx_q == '0) begin
          op_o    = OP_WRITE_NEW;
          count_d = count_q + CW'(1);
        end
      end
      S_INS_CMP: begin
        rd_addr_o = idx_q - AW'(1);
        if (stat_i.cmp_le) begin
          op_o  = OP_SHIFT;
          idx_d = idx_q - AW'(1);
        end else begin
          op_o    = OP_WRITE_NEW;
          count_d = count_q + CW'(1);
        end
      end
      S_Q_RD: ;
      S_Q_CMP: begin
        if (hit_w) begin
          if (idx_q == '0) begin
            op_o = OP_CLAMP;
          end else begin
            op_o  = OP_SEG;
            cnt_d = '0;
          end
        end else if (last_w) begin
          op_o = OP_CLAMP;
        end else begin
          op_o  = OP_SAVE;
          idx_d = idx_q + AW'(1);
        end
      end
      S_DIV: begin
        op_o  = OP_DIV_STEP;
        cnt_d = cnt_q + NW'(1);
      end
      S_MODE: begin
        case (stat_i.left_mode)
          MODE_LINEAR: op_o = OP_NONE;
          MODE_BEZIER: op_o = OP_NONE;
          default:     op_o = OP_HOLD;
        endcase
      end
      S_MT2:      op_o = OP_MUL_MT2;
      S_TT2:      op_o = OP_MUL_TT2;
      S_TT3:      op_o = OP_MUL_TT3;
      S_P1A:      op_o = OP_MUL_P1A;
      S_P1B:      op_o = OP_MUL_P1B;
      S_P2A:      op_o = OP_MUL_P2A;
      S_P2B:      op_o = OP_MUL_P2B;
      S_ACC:      op_o = OP_ACC;
      S_MUL_EASE: op_o = OP_MUL_EASE;
      S_MUL_LIN:  op_o = OP_MUL_LIN;
      S_FIN:      op_o = OP_FINAL;
      S_DONE: begin
        if (out_free_w) begin
          op_o        = OP_EMIT;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      count_q     <= '0;
      st_q        <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      count_q     <= count_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  logic [1:0] status_q;
  logic [6:0] held_q;

  always_ff @(posedge clk_i) begin
    if (op_o == OP_EMIT) begin
      status_q <= st_q;
      held_q   <= 7'(count_q);
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign keys_held_o = held_q;

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_KEYS))
    else $error("key count above table size");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_w && command_i == CMD_INSERT && count_q == CW'(MAX_KEYS))
      |=> count_q == $past(count_q))
    else $error("insert into full table changed count");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == $past(count_q)) || (count_q == $past(count_q) + CW'(1)))
    else $error("key count moved by more than one");

  a_emit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result raised outside completion");

endmodule

/* rtl/keyframe_curve_evaluator.sv */
// Keyframe curve evaluator top level: ties controller and datapath together.
// Depends on kce_pkg, kce_ctrl, kce_datapath (and kce_ram below it).
//
// One item at a time; in_stall_o is high from acceptance until the result is
// handed to the output register, which may still hold an earlier result while
// the next item is taken. An insert walks down from the top of the table,
// reading each key (registered RAM read), comparing it and moving it up one
// place until the new key's slot is found. A query reads keys from the bottom
// up to the segment, then runs a bit-serial division for 16 quotient bits,
// then the hold, linear or Bezier step (Bezier: all products through one shared
// 34x26 multiplier). Completion waits while the output register is still
// stalled; a clamped or empty query finishes early.
module keyframe_curve_evaluator #(
  parameter int unsigned MAX_KEYS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic signed [31:0] time_point_i,
  input  logic signed [31:0] key_value_i,
  input  logic [1:0]         interp_mode_i,
  input  logic signed [15:0] out_handle_i,
  input  logic signed [15:0] in_handle_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] result_value_o,
  output logic [1:0]         status_o,
  output logic [6:0]         keys_held_o
);
  import kce_pkg::*;

  localparam int unsigned AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

  dp_op_e        op_w;
  dp_stat_t      stat_w;
  logic [AW-1:0] rd_addr_w;
  logic [AW-1:0] wr_addr_w;

  kce_ctrl #(
    .MAX_KEYS (MAX_KEYS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .keys_held_o (keys_held_o),
    .op_o        (op_w),
    .rd_addr_o   (rd_addr_w),
    .wr_addr_o   (wr_addr_w),
    .stat_i      (stat_w)
  );

  kce_datapath #(
    .MAX_KEYS (MAX_KEYS)
  ) u_dp (
    .clk_i          (clk_i),
    .time_point_i   (time_point_i),
    .key_value_i    (key_value_i),
    .interp_mode_i  (interp_mode_i),
    .out_handle_i   (out_handle_i),
    .in_handle_i    (in_handle_i),
    .op_i           (op_w),
    .rd_addr_i      (rd_addr_w),
    .wr_addr_i      (wr_addr_w),
    .stat_o         (stat_w),
    .result_value_o (result_value_o)
  );

endmodule

/* test/testbench.sv */
// Testbench for keyframe_curve_evaluator: directed and random inserts and
// queries, checked against a sorted-table curve predictor. Depends on kce_pkg and keyframe_curve_evaluator.
`timescale 1ns / 1ps
module testbench;
  import kce_pkg::*;

  localparam int unsigned NKEYS = 64;
  localparam int unsigned WDOG_LIMIT = 20000;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] tp;
    logic signed [31:0] kv;
    logic [1:0]         mode;
    logic signed [15:0] oh;
    logic signed [15:0] ih;
  } item_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic [1:0]         st;
    logic [6:0]         held;
  } curve_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic command_i = 1'b0;
  logic signed [31:0] time_point_i = '0;
  logic signed [31:0] key_value_i = '0;
  logic [1:0] interp_mode_i = '0;
  logic signed [15:0] out_handle_i = '0;
  logic signed [15:0] in_handle_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] result_value_o;
  logic [1:0] status_o;
  logic [6:0] keys_held_o;

  keyframe_curve_evaluator #(.MAX_KEYS(NKEYS)) dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  item_t      pending_q[$];
  curve_res_t expected_q[$];
  int errors = 0;
  int n_ins = 0, n_qry = 0, n_full = 0, n_empty = 0;
  bit quiet = 1'b0;
  bit hold_rx = 1'b0;

  // predictor state
  logic signed [31:0] p_time[NKEYS];
  logic signed [31:0] p_val[NKEYS];
  logic [1:0]         p_mode[NKEYS];
  logic signed [15:0] p_oh[NKEYS];
  logic signed [15:0] p_ih[NKEYS];
  int unsigned        p_count = 0;

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint curve_at(longint q);
    int unsigned hi;
    longint t1, t2, v1, v2, t, dv, mt, mt2, tt2, tt3, acc, ease, ohv, ihv;
    hi = 0;
    if (q <= p_time[0]) return p_val[0];
    if (q >= p_time[p_count-1]) return p_val[p_count-1];
    while (hi < p_count && p_time[hi] <= q) hi++;
    t1 = p_time[hi-1];
    t2 = p_time[hi];
    v1 = p_val[hi-1];
    v2 = p_val[hi];
    t = ((q - t1) <<< 16) / (t2 - t1);
    dv = v2 - v1;
    case (p_mode[hi-1])
      MODE_LINEAR: return sat32(v1 + ((dv * t) >>> 16));
      MODE_BEZIER: begin
        mt = 65536 - t;
        mt2 = (mt * mt) >>> 16;
        tt2 = (t * t) >>> 16;
        tt3 = (tt2 * t) >>> 16;
        ohv = p_oh[hi-1];
        ihv = p_ih[hi];
        acc = 3 * ohv * mt2 * t + 3 * (16384 - ihv) * mt * tt2 + (tt3 <<< 30);
        ease = acc >>> 30;
        return sat32(v1 + ((dv * ease) >>> 16));
      end
      default: return v1;
    endcase
  endfunction

  function automatic curve_res_t apply_item(item_t it);
    curve_res_t r;
    int unsigned pos;
    r = '0;
    if (it.cmd == CMD_INSERT) begin
      if (p_count >= NKEYS) begin
        r.st = ST_FULL;
      end else begin
        pos = 0;
        while (pos < p_count && p_time[pos] < it.tp) pos++;
        for (int unsigned i = p_count; i > pos; i--) begin
          p_time[i] = p_time[i-1];
          p_val[i] = p_val[i-1];
          p_mode[i] = p_mode[i-1];
          p_oh[i] = p_oh[i-1];
          p_ih[i] = p_ih[i-1];
        end
        p_time[pos] = it.tp;
        p_val[pos] = it.kv;
        p_mode[pos] = it.mode;
        p_oh[pos] = it.oh;
        p_ih[pos] = it.ih;
        p_count++;
      end
    end else if (p_count == 0) begin
      r.st = ST_EMPTY;
    end else begin
      r.val = 32'(curve_at(longint'(it.tp)));
    end
    r.held = 7'(p_count);
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic item_t rnd_item(bit cmd, int span);
    item_t it;
    it.cmd = cmd;
    it.tp = (span == 0) ? $signed($urandom) : $signed($urandom_range(2*span, 0) - span);
    it.kv = ($urandom_range(3, 0) == 0) ? $signed($urandom)
                                        : $signed($urandom_range(200000, 0) - 100000);
    it.mode = 2'($urandom_range(3, 0));
    it.oh = 16'($urandom);
    it.ih = 16'($urandom);
    return it;
  endfunction

  // driver
  int tx_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        void'(pending_q.pop_front());
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_valid_i <= 1'b0;
        end else if (!quiet && $urandom_range(7, 0) == 0) begin
          tx_gap <= $urandom_range(18, 1);
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_valid_i <= 1'b1;
          command_i <= pending_q[0].cmd;
          time_point_i <= pending_q[0].tp;
          key_value_i <= pending_q[0].kv;
          interp_mode_i <= pending_q[0].mode;
          out_handle_i <= pending_q[0].oh;
          in_handle_i <= pending_q[0].ih;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // predictor taps the accepted item at the edge
  always @(posedge clk_i) begin
    item_t it;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      it = '{command_i, time_point_i, key_value_i, interp_mode_i, out_handle_i, in_handle_i};
      expected_q.push_back(apply_item(it));
      if (it.cmd == CMD_INSERT) n_ins++; else n_qry++;
    end
  end

  // monitor and receiver stall
  int rx_gap = 0;
  always @(posedge clk_i) begin
    curve_res_t w;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", result_value_o, 0);
        end else begin
          w = expected_q.pop_front();
          if (result_value_o !== w.val) report("result_value", result_value_o, w.val);
          if (status_o !== w.st) report("status", status_o, w.st);
          if (keys_held_o !== w.held) report("keys_held", keys_held_o, w.held);
          if (w.st == ST_FULL) n_full++;
          if (w.st == ST_EMPTY) n_empty++;
        end
      end
      if (hold_rx) begin
        out_stall_i <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(7, 0) == 0) begin
        rx_gap <= $urandom_range(18, 1);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || hold_rx)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_LIMIT) begin
      $display("watchdog expired");
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_q.size() > 0 || expected_q.size() > 0) @(posedge clk_i);
  endtask

  task automatic push_q(bit cmd, int tp);
    item_t it;
    it = rnd_item(cmd, 0);
    it.tp = tp;
    pending_q.push_back(it);
  endtask

  initial begin
    item_t it;
    int hold_cnt;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty query, single key, extremes, every mode, equal times
    push_q(CMD_QUERY, 0);
    it = '{CMD_INSERT, 32'sh0001_0000, 32'sh7fff_ffff, MODE_BEZIER, 16'sh7fff, 16'sh8000};
    pending_q.push_back(it);
    push_q(CMD_QUERY, 0);
    push_q(CMD_QUERY, 32'sh0002_0000);
    it = '{CMD_INSERT, 32'sh0003_0000, 32'sh8000_0000, MODE_LINEAR, 16'sh8000, 16'sh7fff};
    pending_q.push_back(it);
    push_q(CMD_QUERY, 32'sh0002_0000);
    push_q(CMD_QUERY, 32'sh0001_8000);
    it = '{CMD_INSERT, 32'sh8000_0000, 32'sh0000_1000, MODE_CONST, 16'sh0, 16'sh0};
    pending_q.push_back(it);
    it = '{CMD_INSERT, 32'sh7fff_ffff, 32'shffff_0000, MODE_HOLD, 16'shffff, 16'shffff};
    pending_q.push_back(it);
    it = '{CMD_INSERT, 32'sh0003_0000, 32'sh0005_0000, MODE_BEZIER, 16'sh4000, 16'sh0};
    pending_q.push_back(it);
    push_q(CMD_QUERY, 32'sh8000_0000);
    push_q(CMD_QUERY, 32'sh7fff_ffff);
    push_q(CMD_QUERY, 32'sh0003_0000);
    push_q(CMD_QUERY, 32'sh0004_0000);
    push_q(CMD_QUERY, 32'shc000_0000);
    push_q(CMD_QUERY, 32'sh4000_0000);
    wait_drained();

    // long receiver hold-off while items keep coming
    hold_rx = 1'b1;
    for (int i = 0; i < 10; i++) pending_q.push_back(rnd_item(1'($urandom_range(1, 0)), 0));
    hold_cnt = 0;
    while (hold_cnt < 300) begin
      @(posedge clk_i);
      hold_cnt++;
    end
    hold_rx = 1'b0;

    // random: mostly queries; inserts fill the table and then hit full, narrow spans first
    for (int i = 0; i < 980; i++) begin
      if (i == 880) quiet = 1'b1;
      if ($urandom_range(2, 0) == 0)
        pending_q.push_back(rnd_item(CMD_INSERT, (i < 500) ? 600000 : 0));
      else
        pending_q.push_back(rnd_item(CMD_QUERY, (i % 3 == 0) ? 0 : 700000));
      if (pending_q.size() > 8) wait (pending_q.size() < 4);
    end
    wait_drained();
    repeat (200) @(posedge clk_i);

    $display("covered %0d inserts and %0d queries, %0d full drops, %0d empty queries",
             n_ins, n_qry, n_full, n_empty);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, expected_q.size());
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/kce_pkg.sv
rtl/kce_ram.sv
rtl/kce_datapath.sv
rtl/kce_ctrl.sv
rtl/keyframe_curve_evaluator.sv
test/testbench.sv
